>>> src/msbbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbbr_pkg
// Shared types and constants for the MSB-first bit reader.
// ----------------------------------------------------------------------------
package msbbr_pkg;

  // Buffer fill limit in bits, and bytes per supplied word
  localparam int WORD_BITS  = 64;
  localparam int WORD_BYTES = WORD_BITS / 8;

  // Physical buffer and value width, count width (holds 0..64)
  localparam int BUF_BITS = 64;
  localparam int CNT_W    = 7;
  localparam int NB_W     = 4;
  localparam int SKIP_W   = 32;

  // Request codes
  typedef enum logic [2:0] {
    FUNC_SUPPLY = 3'd0,
    FUNC_READ   = 3'd1,
    FUNC_UNREAD = 3'd2,
    FUNC_SKIP   = 3'd3,
    FUNC_EOS    = 3'd4
  } func_t;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_EOS_EMPTY = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Request payload
  typedef struct packed {
    logic [2:0]          func;
    logic [BUF_BITS-1:0] word_data;
    logic [NB_W-1:0]     word_bytes;
    logic [CNT_W-1:0]    read_bits;
    logic [BUF_BITS-1:0] unread_value;
    logic [CNT_W-1:0]    unread_bits;
    logic [SKIP_W-1:0]   skip_bits;
  } req_t;

endpackage

>>> src/msbbr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msbbr_if
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
interface msbbr_req_if import msbbr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          func;
  logic [BUF_BITS-1:0] word_data;
  logic [NB_W-1:0]     word_bytes;
  logic [CNT_W-1:0]    read_bits;
  logic [BUF_BITS-1:0] unread_value;
  logic [CNT_W-1:0]    unread_bits;
  logic [SKIP_W-1:0]   skip_bits;

  modport source (
    output valid, func, word_data, word_bytes, read_bits,
           unread_value, unread_bits, skip_bits,
    input  ready
  );
  modport sink (
    input  valid, func, word_data, word_bytes, read_bits,
           unread_value, unread_bits, skip_bits,
    output ready
  );
endinterface

interface msbbr_rsp_if import msbbr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BUF_BITS-1:0] value;
  logic [CNT_W-1:0]    bits_done;
  logic [1:0]          status;

  modport source (output valid, value, bits_done, status, input ready);
  modport sink   (input  valid, value, bits_done, status, output ready);
endinterface

>>> src/msb_first_bit_reader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_reader_core
// MSB-first bit reader: 64-bit left-aligned buffer, pending reads and skips,
// unread push-back and end-of-stream flush.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload                                    | Handshake
//  req     | in        | func, word_data, word_bytes, read_bits,    | valid/ready
//          |           | unread_value, unread_bits, skip_bits       |
//  rsp     | out       | value, bits_done, status                   | valid/ready
//
//  One request per cycle while rsp is not stalled. The request register loads
//  at the transaction edge and the result register loads from it when the
//  request is handled; rsp shows the result register. Each request is
//  handled by a funnel shift and count update against the buffer state. A
//  request that gives no result just retires. rst (synchronous) clears the
//  buffer, counts and pending flags. A result held by a stalled rsp stalls
//  the request register, and req.ready drops only then.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_core import msbbr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  msbbr_req_if.sink    req,
  msbbr_rsp_if.source  rsp
);

  // Request register
  logic s1_valid;
  req_t s1_req;
  logic s1_go;

  // Reader state
  logic [BUF_BITS-1:0] bit_buffer, bit_buffer_next;
  logic [CNT_W-1:0]    buffered_bits, buffered_bits_next;
  logic                read_pending, read_pending_next;
  logic [BUF_BITS-1:0] partial_value, partial_value_next;
  logic [CNT_W-1:0]    read_left, read_left_next;
  logic [CNT_W-1:0]    read_total, read_total_next;
  logic [SKIP_W-1:0]   skip_left, skip_left_next;

  // Result register
  logic                res_valid;
  logic [BUF_BITS-1:0] res_value;
  logic [CNT_W-1:0]    res_bits_done;
  logic [1:0]          res_status;

  // Combinational result of the current request
  logic                r_load;
  logic [BUF_BITS-1:0] r_value;
  logic [CNT_W-1:0]    r_bits_done;
  logic [1:0]          r_status;

  // Handshake
  assign s1_go     = s1_valid && (!res_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req.func         <= req.func;
      s1_req.word_data    <= req.word_data;
      s1_req.word_bytes   <= req.word_bytes;
      s1_req.read_bits    <= req.read_bits;
      s1_req.unread_value <= req.unread_value;
      s1_req.unread_bits  <= req.unread_bits;
      s1_req.skip_bits    <= req.skip_bits;
    end
  end

  // Request handling
  logic [NB_W-1:0]     nb;
  logic [CNT_W-1:0]    nbits;
  logic [BUF_BITS-1:0] word_m;
  logic [CNT_W-1:0]    sk;
  logic [BUF_BITS-1:0] buf1;
  logic [CNT_W-1:0]    cnt1;
  logic [CNT_W-1:0]    k2;
  logic [BUF_BITS-1:0] taken;
  logic [CNT_W-1:0]    n_rd;
  logic [CNT_W-1:0]    n_un;
  logic [CNT_W:0]      un_sum;
  logic [2*BUF_BITS-1:0] un_cat;
  logic [CNT_W-1:0]    got;

  always_comb begin
    bit_buffer_next    = bit_buffer;
    buffered_bits_next = buffered_bits;
    read_pending_next  = read_pending;
    partial_value_next = partial_value;
    read_left_next     = read_left;
    read_total_next    = read_total;
    skip_left_next     = skip_left;
    r_load      = 1'b0;
    r_value     = '0;
    r_bits_done = '0;
    r_status    = ST_OK;

    // Supplied word: mask to its bytes, drop skipped bits from the top
    nb     = (s1_req.word_bytes > NB_W'(WORD_BYTES)) ? NB_W'(WORD_BYTES)
                                                     : s1_req.word_bytes;
    nbits  = {nb, 3'b000};
    word_m = s1_req.word_data & ~({BUF_BITS{1'b1}} >> nbits);
    sk     = (skip_left < SKIP_W'(nbits)) ? skip_left[CNT_W-1:0] : nbits;
    buf1   = (s1_req.func == FUNC_SUPPLY) ? (word_m << sk) : bit_buffer;
    cnt1   = (s1_req.func == FUNC_SUPPLY) ? (nbits - sk) : buffered_bits;

    // Read count and bits taken from the buffer top
    n_rd  = (s1_req.read_bits > CNT_W'(BUF_BITS)) ? CNT_W'(BUF_BITS)
                                                  : s1_req.read_bits;
    if (s1_req.func == FUNC_SUPPLY) begin
      k2 = (read_left < cnt1) ? read_left : cnt1;
    end else begin
      k2 = (n_rd < cnt1) ? n_rd : cnt1;
    end
    taken = (k2 == '0) ? '0 : (buf1 >> (CNT_W'(BUF_BITS) - k2));

    // Unread push-back
    n_un   = (s1_req.unread_bits > CNT_W'(BUF_BITS)) ? CNT_W'(BUF_BITS)
                                                     : s1_req.unread_bits;
    un_sum = {1'b0, buffered_bits} + {1'b0, n_un};
    un_cat = {s1_req.unread_value, bit_buffer} >> n_un;

    got = read_total - read_left;

    case (func_t'(s1_req.func))
      FUNC_SUPPLY: begin
        if (buffered_bits != '0) begin
          r_load   = 1'b1;
          r_status = ST_BUSY;
        end else if (nb != '0) begin
          skip_left_next     = skip_left - SKIP_W'(sk);
          bit_buffer_next    = buf1;
          buffered_bits_next = cnt1;
          if (read_pending) begin
            bit_buffer_next    = buf1 << k2;
            buffered_bits_next = cnt1 - k2;
            partial_value_next = (partial_value << k2) | taken;
            read_left_next     = read_left - k2;
            if (read_left == k2) begin
              read_pending_next = 1'b0;
              r_load      = 1'b1;
              r_value     = (partial_value << k2) | taken;
              r_bits_done = read_total;
            end
          end
        end
      end
      FUNC_READ: begin
        r_load = 1'b1;
        if (read_pending) begin
          r_status = ST_BUSY;
        end else if (n_rd != '0) begin
          bit_buffer_next    = buf1 << k2;
          buffered_bits_next = cnt1 - k2;
          partial_value_next = taken;
          read_left_next     = n_rd - k2;
          read_total_next    = n_rd;
          if (n_rd == k2) begin
            r_value     = taken;
            r_bits_done = n_rd;
          end else begin
            read_pending_next = 1'b1;
            r_load            = 1'b0;
          end
        end
      end
      FUNC_UNREAD: begin
        r_load = 1'b1;
        if (read_pending || skip_left != '0) begin
          r_status = ST_BUSY;
        end else if (n_un != '0) begin
          if (un_sum > (CNT_W+1)'(WORD_BITS)) begin
            r_status = ST_OVERFLOW;
          end else begin
            bit_buffer_next    = un_cat[BUF_BITS-1:0];
            buffered_bits_next = un_sum[CNT_W-1:0];
            r_bits_done        = n_un;
          end
        end
      end
      FUNC_SKIP: begin
        r_load = 1'b1;
        if (read_pending || skip_left != '0) begin
          r_status = ST_BUSY;
        end else if (s1_req.skip_bits < SKIP_W'(buffered_bits)) begin
          bit_buffer_next    = bit_buffer << s1_req.skip_bits[CNT_W-1:0];
          buffered_bits_next = buffered_bits - s1_req.skip_bits[CNT_W-1:0];
          skip_left_next     = '0;
          r_bits_done        = s1_req.skip_bits[CNT_W-1:0];
        end else begin
          bit_buffer_next    = '0;
          buffered_bits_next = '0;
          skip_left_next     = s1_req.skip_bits - SKIP_W'(buffered_bits);
          r_bits_done        = buffered_bits;
        end
      end
      FUNC_EOS: begin
        r_load         = 1'b1;
        skip_left_next = '0;
        if (read_pending) begin
          read_pending_next = 1'b0;
          read_left_next    = '0;
          r_value           = partial_value;
          r_bits_done       = got;
          r_status          = (got != '0) ? ST_OK : ST_EOS_EMPTY;
        end else begin
          r_status = (buffered_bits != '0) ? ST_OK : ST_EOS_EMPTY;
        end
      end
      default: begin
        r_load = 1'b0;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer    <= '0;
      buffered_bits <= '0;
      read_pending  <= 1'b0;
      partial_value <= '0;
      read_left     <= '0;
      read_total    <= '0;
      skip_left     <= '0;
    end else if (s1_go) begin
      bit_buffer    <= bit_buffer_next;
      buffered_bits <= buffered_bits_next;
      read_pending  <= read_pending_next;
      partial_value <= partial_value_next;
      read_left     <= read_left_next;
      read_total    <= read_total_next;
      skip_left     <= skip_left_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go) begin
      res_valid <= r_load;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && r_load) begin
      res_value     <= r_value;
      res_bits_done <= r_bits_done;
      res_status    <= r_status;
    end
  end

  assign rsp.valid     = res_valid;
  assign rsp.value     = res_value;
  assign rsp.bits_done = res_bits_done;
  assign rsp.status    = res_status;

endmodule
